>>> hdl/knndl_pkg.sv
package knndl_pkg;

  // List depth and stored distance width.
  localparam int K_MAX     = 16;
  localparam int DIST_BITS = 32;

  // Fixed field widths of the ports.
  localparam int FIELD_W = 32;
  localparam int K_W     = 5;
  localparam int SUM_W   = 36;

  // Derived widths.
  localparam int CNT_W  = $clog2(K_MAX + 1);
  localparam int IDX_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int PROD_W = CNT_W + FIELD_W;
  localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  // Neighbour count after reset.
  localparam logic [K_W-1:0] K_RESET = K_W'(16);

  typedef logic [DIST_BITS-1:0] dist_t;

  // Step commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic update;
    logic accum;
    logic finish;
  } cmd_t;

  // Clamp the programmed neighbour count into 1..K_MAX.
  function automatic logic [CNT_W-1:0] eff_k(input logic [K_W-1:0] k);
    logic [CNT_W-1:0] r;
    if (k == '0) begin
      r = CNT_W'(1);
    end else if (int'(k) > K_MAX) begin
      r = CNT_W'(K_MAX);
    end else begin
      r = CNT_W'(k);
    end
    return r;
  endfunction

endpackage

>>> hdl/knndl_ctrl.sv
module knndl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output knndl_pkg::cmd_t cmd_o
);
  import knndl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_ACCUM,
    S_CHECK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // The result register is free when empty or being taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and step commands.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = S_ACCUM;
      end
      S_ACCUM: begin
        cmd_o.accum = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/knndl_dp.sv
module knndl_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  knndl_pkg::cmd_t              cmd_i,
  input  logic                         cfg_we_i,
  input  logic [knndl_pkg::K_W-1:0]    cfg_k_i,
  input  logic                         first_of_query_i,
  input  logic [knndl_pkg::FIELD_W-1:0] distance_sq_i,
  input  logic [knndl_pkg::FIELD_W-1:0] cutoff_score_i,
  output logic [knndl_pkg::SUM_W-1:0]  score_sum_o,
  output logic                         list_full_o,
  output logic                         pruned_o
);
  import knndl_pkg::*;

  // Sorted list cells; entries at or beyond the count are never compared.
  dist_t             list_q [K_MAX];
  dist_t             cell_d [K_MAX];

  logic [K_W-1:0]    k_cfg_q;
  dist_t             d_q;
  logic [FIELD_W-1:0] cutoff_q;
  logic [CNT_W-1:0]  count_q;
  logic [SUM_W-1:0]  sum_q;
  logic              pruned_q;
  logic [PROD_W-1:0] prod_q;
  dist_t             largest_q;
  logic              add_q;
  logic              sub_q;
  logic [SUM_W-1:0]  out_sum_q;
  logic              out_full_q;
  logic              out_pruned_q;

  logic [CNT_W-1:0]  keff;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  top_idx;
  dist_t             largest;
  logic              ins;
  logic              rep;
  logic              place;
  logic [CNT_W-1:0]  len;
  logic              full;
  logic              prune_now;
  logic              gt;
  logic              prev_gt;
  dist_t             prev_val;

  assign keff    = eff_k(k_cfg_q);
  assign cnt_m1  = count_q - CNT_W'(1);
  assign top_idx = cnt_m1[IDX_W-1:0];
  assign largest = list_q[top_idx];

  // Insert while short of k, replace the largest once full.
  assign ins   = (count_q < keff);
  assign rep   = !ins && (count_q != '0) && (int'(count_q) <= K_MAX) && (d_q < largest);
  assign place = !pruned_q && (ins || rep);
  assign len   = ins ? count_q : cnt_m1;

  // Compare-and-shift cells: each slot keeps, takes the new distance,
  // or takes its lower neighbour.
  always_comb begin
    prev_gt  = 1'b0;
    prev_val = d_q;
    for (int i = 0; i < K_MAX; i++) begin
      gt        = (CNT_W'(i) >= len) || (list_q[i] > d_q);
      cell_d[i] = list_q[i];
      if ((CNT_W'(i) <= len) && gt) begin
        cell_d[i] = prev_gt ? prev_val : d_q;
      end
      prev_gt  = gt;
      prev_val = list_q[i];
    end
  end

  // Prune test on the updated list.
  assign full      = (count_q >= keff);
  assign prune_now = !pruned_q && full && (CMP_W'(sum_q) < CMP_W'(prod_q));

  // List storage.
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && place) begin
      for (int i = 0; i < K_MAX; i++) begin
        list_q[i] <= cell_d[i];
      end
    end
  end

  // Request capture and step operands.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      d_q      <= distance_sq_i[DIST_BITS-1:0];
      cutoff_q <= cutoff_score_i;
    end
    if (cmd_i.update) begin
      prod_q    <= PROD_W'(keff) * PROD_W'(cutoff_q);
      largest_q <= largest;
      add_q     <= place;
      sub_q     <= !pruned_q && rep;
    end
    if (cmd_i.finish) begin
      out_sum_q    <= prune_now ? '0 : sum_q;
      out_full_q   <= full;
      out_pruned_q <= pruned_q || prune_now;
    end
  end

  // Query state and the configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q  <= K_RESET;
      count_q  <= '0;
      sum_q    <= '0;
      pruned_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        k_cfg_q <= cfg_k_i;
      end
      if (cmd_i.capture && first_of_query_i) begin
        count_q  <= '0;
        sum_q    <= '0;
        pruned_q <= 1'b0;
      end
      if (cmd_i.update && !pruned_q && ins) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.accum) begin
        sum_q <= sum_q + (add_q ? SUM_W'(d_q) : '0) - (sub_q ? SUM_W'(largest_q) : '0);
      end
      if (cmd_i.finish && prune_now) begin
        pruned_q <= 1'b1;
        sum_q    <= '0;
      end
    end
  end

  assign score_sum_o = out_sum_q;
  assign list_full_o = out_full_q;
  assign pruned_o    = out_pruned_q;

endmodule

>>> hdl/knn_distance_list_with_prune_top.sv
// Nearest-neighbour distance list with mean-cutoff pruning.
// Input channel: in_valid_i / in_stall_o carry one request of first_of_query_i,
// distance_sq_i and cutoff_score_i; it is taken when valid is high and stall
// is low. Each request gives exactly one result on out_valid_o / out_stall_i
// with score_sum_o, list_full_o and pruned_o; the result is taken when valid
// is high and out_stall_i is low.
// The neighbour count is written on cfg_valid_i / cfg_ready_o with
// cfg_k_in_use_i; ready is always high and writes belong between queries.
// A request passes four steps: capture, list update through the
// compare-and-shift cells, sum update, prune test, and its result is
// registered when the prune test ends. No new request is taken until the
// current one has left the prune-test step, as set by the controller's
// step sequence over the shared list and sum datapath.
// While the receiver stalls, a finished result is held in the output register
// and the next request is still taken; its result waits in the prune-test
// step until the output register is free.
// Reset clears the count, sum and pruned mark, empties the output register
// and sets the neighbour count to 16. The list needs no clearing.
module knn_distance_list_with_prune_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          first_of_query_i,
  input  logic [knndl_pkg::FIELD_W-1:0] distance_sq_i,
  input  logic [knndl_pkg::FIELD_W-1:0] cutoff_score_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [knndl_pkg::SUM_W-1:0]   score_sum_o,
  output logic                          list_full_o,
  output logic                          pruned_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [knndl_pkg::K_W-1:0]     cfg_k_in_use_i
);
  import knndl_pkg::*;

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Step sequencer.
  knndl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // List, sum and prune datapath.
  knndl_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_k_i          (cfg_k_in_use_i),
    .first_of_query_i (first_of_query_i),
    .distance_sq_i    (distance_sq_i),
    .cutoff_score_i   (cutoff_score_i),
    .score_sum_o      (score_sum_o),
    .list_full_o      (list_full_o),
    .pruned_o         (pruned_o)
  );

endmodule

>>> hdl/knndl_chk.sv
module knndl_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          first_of_query_i,
  input logic [knndl_pkg::FIELD_W-1:0] distance_sq_i,
  input logic [knndl_pkg::FIELD_W-1:0] cutoff_score_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [knndl_pkg::SUM_W-1:0]   score_sum_o,
  input logic                          list_full_o,
  input logic                          pruned_o,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [knndl_pkg::K_W-1:0]     cfg_k_in_use_i
);

  // A stalled result holds its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_sum_o)
      && $stable(list_full_o) && $stable(pruned_o))
    else $error("stalled result changed");

  // A pruned query always reports a zero sum.
  a_pruned_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pruned_o |-> score_sum_o == '0)
    else $error("pruned result with nonzero sum");

  // After a request is taken the block stays busy through its steps.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o ##1 in_stall_o ##1 in_stall_o)
    else $error("request accepted during processing");

  // A new result needs a request in flight: the block must have been busy before it.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o, 1) && $past(in_stall_o, 2))
    else $error("result without a request in flight");

endmodule

bind knn_distance_list_with_prune_top knndl_chk u_chk (.*);
